/* rtl/source_line_classifier_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the source line classifier
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SOURCE_LINE_CLASSIFIER_TOP_ASSERT_SVH
`define SOURCE_LINE_CLASSIFIER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SLC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slc assertion failed: same-cycle implication");

// next-cycle implication
`define SLC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slc assertion failed: next-cycle implication");

`else

`define SLC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SLC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/slc_pkg.sv */
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types and character constants for the source line classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slc_pkg;

  // character codes
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_STAR  = 8'd42;

  // input command
  typedef enum logic {
    CMD_CHAR = 1'b0,
    CMD_EOF  = 1'b1
  } cmd_t;

  // line classes
  typedef enum logic [1:0] {
    CLS_BLANK   = 2'd0,
    CLS_COMMENT = 2'd1,
    CLS_CODE    = 2'd2
  } line_class_t;

  // per-line scanner flags plus the cross-line block comment flag
  typedef struct packed {
    logic in_block;
    logic seen_nonblank;
    logic maybe_start;
    logic maybe_end;
    logic is_comment;
    logic block_closed;
    logic skip_rest;
    logic line_open;
  } line_flags_t;

  // counter bump requests for one beat
  typedef struct packed {
    logic blank;
    logic comment;
    logic code;
    logic file;
  } count_ev_t;

endpackage

`default_nettype wire

/* rtl/slc_line_tracker.sv */
// ----------------------------------------------------------------------------
// slc_line_tracker
// Character flag scanner: holds the line flags, classifies completed lines
// and raises counter events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "source_line_classifier_top_assert.svh"

module slc_line_tracker (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire logic                  cmd,
  input  wire logic [7:0]            char_byte,
  output logic                       line_done,
  output slc_pkg::line_class_t       line_class,
  output slc_pkg::count_ev_t         ev
);

  slc_pkg::line_flags_t flags_r;
  slc_pkg::line_flags_t flags_nxt;
  slc_pkg::line_class_t cur_class;
  logic                 is_blank;
  logic                 is_slash;
  logic                 is_star;
  logic                 eof_clean;

  assign is_blank = (char_byte == slc_pkg::CH_SPACE) || (char_byte == slc_pkg::CH_TAB);
  assign is_slash = (char_byte == slc_pkg::CH_SLASH);
  assign is_star  = (char_byte == slc_pkg::CH_STAR);

  // class of the line as it stands
  always_comb begin
    if (!flags_r.seen_nonblank) begin
      cur_class = slc_pkg::CLS_BLANK;
    end else if (flags_r.is_comment) begin
      cur_class = slc_pkg::CLS_COMMENT;
    end else begin
      cur_class = slc_pkg::CLS_CODE;
    end
  end

  // next flags, line completion and counter events
  always_comb begin
    flags_nxt  = flags_r;
    line_done  = 1'b0;
    line_class = slc_pkg::CLS_BLANK;
    ev         = '0;
    if (step) begin
      if (cmd == slc_pkg::CMD_EOF) begin
        // close an open last line, drop block state, count the file
        line_done  = flags_r.line_open;
        line_class = flags_r.line_open ? cur_class : slc_pkg::CLS_BLANK;
        flags_nxt  = '0;
        ev.file    = 1'b1;
      end else if (char_byte == slc_pkg::CH_NL) begin
        line_done          = 1'b1;
        line_class         = cur_class;
        flags_nxt          = '0;
        flags_nxt.in_block = flags_r.in_block;
      end else begin
        flags_nxt.line_open = 1'b1;
        if (flags_r.skip_rest) begin
          // rest of line after a double slash is ignored
        end else if (!flags_r.seen_nonblank) begin
          if (!is_blank) begin
            flags_nxt.seen_nonblank = 1'b1;
            if (is_slash) begin
              flags_nxt.maybe_start = 1'b1;
            end else if (is_star && flags_r.in_block) begin
              flags_nxt.maybe_end = 1'b1;
            end
          end
        end else if (flags_r.in_block) begin
          flags_nxt.is_comment = 1'b1;
          if (flags_r.maybe_end && is_slash) begin
            flags_nxt.in_block     = 1'b0;
            flags_nxt.block_closed = 1'b1;
          end
          if (is_star) begin
            flags_nxt.maybe_end = 1'b1;
          end
        end else if (flags_r.maybe_start && is_slash) begin
          // double slash: keep the start/end marks as they are
          flags_nxt.is_comment = 1'b1;
          flags_nxt.skip_rest  = 1'b1;
        end else begin
          if (flags_r.maybe_start) begin
            if (is_star) begin
              flags_nxt.is_comment = 1'b1;
              flags_nxt.in_block   = 1'b1;
            end
          end else if (flags_r.block_closed && flags_r.is_comment && !is_blank) begin
            // text after a closing star-slash makes the line code again
            flags_nxt.is_comment = 1'b0;
          end
          flags_nxt.maybe_start = 1'b0;
          flags_nxt.maybe_end   = 1'b0;
        end
      end
      if (line_done) begin
        case (line_class)
          slc_pkg::CLS_BLANK:   ev.blank   = 1'b1;
          slc_pkg::CLS_COMMENT: ev.comment = 1'b1;
          slc_pkg::CLS_CODE:    ev.code    = 1'b1;
          default:              ev.code    = 1'b0;
        endcase
      end
    end
  end

  // flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  assign eof_clean = !flags_r.in_block && !flags_r.line_open;

  // a double slash always marks the line as comment
  `SLC_ASSERT_IMP(a_skip_is_comment, clk, rst_n, flags_r.skip_rest, flags_r.is_comment)
  // end of file leaves no block comment and no open line
  `SLC_ASSERT_NXT(a_eof_clears, clk, rst_n, step && (cmd == slc_pkg::CMD_EOF), eof_clean)

endmodule

`default_nettype wire

/* rtl/slc_counters.sv */
// ----------------------------------------------------------------------------
// slc_counters
// Saturating blank, comment, code and file counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "source_line_classifier_top_assert.svh"

module slc_counters #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire slc_pkg::count_ev_t     ev,
  output logic [COUNT_WIDTH-1:0]      blank_cnt,
  output logic [COUNT_WIDTH-1:0]      comment_cnt,
  output logic [COUNT_WIDTH-1:0]      code_cnt,
  output logic [COUNT_WIDTH-1:0]      file_cnt
);

  logic [COUNT_WIDTH-1:0] blank_r;
  logic [COUNT_WIDTH-1:0] comment_r;
  logic [COUNT_WIDTH-1:0] code_r;
  logic [COUNT_WIDTH-1:0] file_r;
  logic [2:0]             line_ev;
  logic                   line_ev_ok;
  logic                   blank_bump;

  // counters hold at all ones
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_r   <= '0;
      comment_r <= '0;
      code_r    <= '0;
      file_r    <= '0;
    end else begin
      if (ev.blank && !(&blank_r)) begin
        blank_r <= blank_r + 1'b1;
      end
      if (ev.comment && !(&comment_r)) begin
        comment_r <= comment_r + 1'b1;
      end
      if (ev.code && !(&code_r)) begin
        code_r <= code_r + 1'b1;
      end
      if (ev.file && !(&file_r)) begin
        file_r <= file_r + 1'b1;
      end
    end
  end

  assign blank_cnt   = blank_r;
  assign comment_cnt = comment_r;
  assign code_cnt    = code_r;
  assign file_cnt    = file_r;

  assign line_ev    = {ev.blank, ev.comment, ev.code};
  assign line_ev_ok = $onehot0(line_ev);
  assign blank_bump = ev.blank && !(&blank_r);

  // a line lands in one class only
  `SLC_ASSERT_IMP(a_one_class, clk, rst_n, 1'b1, line_ev_ok)
  // unsaturated blank counter steps by exactly one
  `SLC_ASSERT_NXT(a_blank_step, clk, rst_n, blank_bump, blank_r == $past(blank_r) + 1'b1)

endmodule

`default_nettype wire

/* rtl/source_line_classifier_top.sv */
// ----------------------------------------------------------------------------
// source_line_classifier_top
// Classifies source lines streamed one byte per beat and keeps line counts.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  input    | in_valid, in_stall, in_command,         | in
//           | in_char_byte                            |
//  result   | out_valid, out_stall, out_line_done,    | out
//           | out_line_class, out_*_count             |
//
// One beat per cycle sustained while out_stall is low; a beat passes the input
// register, then the flag/counter update that loads the result register.
// Every input beat yields exactly one result beat.
// Reset (rst_n low, synchronous) clears all flags and counters at once.
// When the result register is full and stalled, in_stall rises once the input
// register is also full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "source_line_classifier_top_assert.svh"

module source_line_classifier_top #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_char_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_line_done,
  output logic [1:0]       out_line_class,
  output logic [31:0]      out_blank_count,
  output logic [31:0]      out_comment_count,
  output logic [31:0]      out_code_count,
  output logic [31:0]      out_file_count
);

  logic                   in_valid_r;
  logic                   in_cmd_r;
  logic [7:0]             in_byte_r;
  logic                   out_valid_r;
  logic                   done_r;
  slc_pkg::line_class_t   class_r;
  logic                   advance;
  logic                   trk_done;
  slc_pkg::line_class_t   trk_class;
  slc_pkg::count_ev_t     trk_ev;
  logic [COUNT_WIDTH-1:0] blank_cnt;
  logic [COUNT_WIDTH-1:0] comment_cnt;
  logic [COUNT_WIDTH-1:0] code_cnt;
  logic [COUNT_WIDTH-1:0] file_cnt;

  // pipeline moves when the result register is free or being drained
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_cmd_r  <= in_command;
      in_byte_r <= in_char_byte;
    end
  end

  slc_line_tracker u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .cmd        (in_cmd_r),
    .char_byte  (in_byte_r),
    .line_done  (trk_done),
    .line_class (trk_class),
    .ev         (trk_ev)
  );

  // counter registers double as the count part of the result register
  slc_counters #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_counters (
    .clk         (clk),
    .rst_n       (rst_n),
    .ev          (trk_ev),
    .blank_cnt   (blank_cnt),
    .comment_cnt (comment_cnt),
    .code_cnt    (code_cnt),
    .file_cnt    (file_cnt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      done_r  <= trk_done;
      class_r <= trk_class;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_line_done     = done_r;
  assign out_line_class    = class_r;
  assign out_blank_count   = 32'(blank_cnt);
  assign out_comment_count = 32'(comment_cnt);
  assign out_code_count    = 32'(code_cnt);
  assign out_file_count    = 32'(file_cnt);

  // no class is reported without a completed line
  `SLC_ASSERT_IMP(a_class_needs_line, clk, rst_n, out_valid_r && !done_r, class_r == slc_pkg::CLS_BLANK)
  // a stalled full pipeline holds its input beat
  `SLC_ASSERT_NXT(a_stall_keeps_input, clk, rst_n, in_stall, in_valid_r)

endmodule

`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for source_line_classifier_top
// Streams directed and random source text, one byte or end-of-file per beat,
// into the classifier. A line tally model predicts the result of every beat
// and checks it field by field. Counters are built 8 bits wide here so that
// random traffic drives the busiest of them into saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int COUNT_W      = 8;
  localparam int IDLE_PCT     = 7;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_BEATS = 2000;
  localparam int SETTLE       = 10;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LETTER = 8'h61;

  localparam longint unsigned TALLY_MAX = (64'd1 << COUNT_W) - 64'd1;

  // one predicted result beat
  typedef struct {
    logic                 done;
    slc_pkg::line_class_t cls;
    logic [31:0]          blank;
    logic [31:0]          comment;
    logic [31:0]          code;
    logic [31:0]          files;
  } line_tally_t;

  // Line tally model: tracks scanner flags and counters, holds pending results.
  class line_tally_board;
    slc_pkg::line_flags_t fl;
    longint unsigned      blank_n, comment_n, code_n, file_n;
    line_tally_t          pending_tallies[$];
    int                   errors;

    function new();
      fl        = '0;
      blank_n   = 0;
      comment_n = 0;
      code_n    = 0;
      file_n    = 0;
      errors    = 0;
    endfunction

    function longint unsigned bump(longint unsigned v);
      return (v >= TALLY_MAX) ? TALLY_MAX : v + 64'd1;
    endfunction

    // per-line flags drop; block comment state survives
    function void clear_line();
      logic keep;
      keep        = fl.in_block;
      fl          = '0;
      fl.in_block = keep;
    endfunction

    function slc_pkg::line_class_t close_line();
      slc_pkg::line_class_t cls;
      if (!fl.seen_nonblank) begin
        cls     = slc_pkg::CLS_BLANK;
        blank_n = bump(blank_n);
      end else if (fl.is_comment) begin
        cls       = slc_pkg::CLS_COMMENT;
        comment_n = bump(comment_n);
      end else begin
        cls    = slc_pkg::CLS_CODE;
        code_n = bump(code_n);
      end
      clear_line();
      return cls;
    endfunction

    // flag rules for one non-newline byte
    function void scan_char(logic [7:0] c);
      logic blank;
      blank        = (c == slc_pkg::CH_SPACE) || (c == slc_pkg::CH_TAB);
      fl.line_open = 1'b1;
      if (fl.skip_rest) return;
      if (!fl.seen_nonblank) begin
        if (!blank) begin
          fl.seen_nonblank = 1'b1;
          if (c == slc_pkg::CH_SLASH) fl.maybe_start = 1'b1;
          else if (c == slc_pkg::CH_STAR && fl.in_block) fl.maybe_end = 1'b1;
        end
      end else if (fl.in_block) begin
        fl.is_comment = 1'b1;
        if (fl.maybe_end && c == slc_pkg::CH_SLASH) begin
          fl.in_block     = 1'b0;
          fl.block_closed = 1'b1;
        end
        if (c == slc_pkg::CH_STAR) fl.maybe_end = 1'b1;
      end else begin
        if (fl.maybe_start) begin
          if (c == slc_pkg::CH_SLASH) begin
            fl.is_comment = 1'b1;
            fl.skip_rest  = 1'b1;
            return;
          end else if (c == slc_pkg::CH_STAR) begin
            fl.is_comment = 1'b1;
            fl.in_block   = 1'b1;
          end
        end else if (fl.block_closed && fl.is_comment) begin
          // text after a closing star-slash makes the line code again
          if (!blank) fl.is_comment = 1'b0;
        end
        fl.maybe_start = 1'b0;
        fl.maybe_end   = 1'b0;
      end
    endfunction

    function void note_input(slc_pkg::cmd_t cmd, logic [7:0] c);
      line_tally_t t;
      t.done = 1'b0;
      t.cls  = slc_pkg::CLS_BLANK;
      if (cmd == slc_pkg::CMD_EOF) begin
        if (fl.line_open) begin
          t.cls  = close_line();
          t.done = 1'b1;
        end
        clear_line();
        fl.in_block = 1'b0;
        file_n      = bump(file_n);
      end else if (c == slc_pkg::CH_NL) begin
        t.cls  = close_line();
        t.done = 1'b1;
      end else begin
        scan_char(c);
      end
      t.blank   = 32'(blank_n);
      t.comment = 32'(comment_n);
      t.code    = 32'(code_n);
      t.files   = 32'(file_n);
      pending_tallies.push_back(t);
    endfunction

    function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
      if (act !== exp) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(logic done, logic [1:0] cls, logic [31:0] blank,
                               logic [31:0] comment, logic [31:0] code,
                               logic [31:0] files);
      line_tally_t t;
      if (pending_tallies.size() == 0) begin
        $display("%0t: result beat with nothing pending, expected none, actual line_done %0d",
                 $time, done);
        errors++;
        return;
      end
      t = pending_tallies.pop_front();
      compare_field("line_done", 32'(t.done), 32'(done));
      compare_field("line_class", 32'(t.cls), 32'(cls));
      compare_field("blank_count", t.blank, blank);
      compare_field("comment_count", t.comment, comment);
      compare_field("code_count", t.code, code);
      compare_field("file_count", t.files, files);
    endfunction

    function int outstanding();
      return pending_tallies.size();
    endfunction
  endclass

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_command   = 1'b0;
  logic [7:0]  in_char_byte = 8'd0;
  logic        out_stall    = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_line_done;
  logic [1:0]  out_line_class;
  logic [31:0] out_blank_count;
  logic [31:0] out_comment_count;
  logic [31:0] out_code_count;
  logic [31:0] out_file_count;

  bit calm_phase = 1'b0;
  bit hold_req   = 1'b0;
  int beats      = 0;

  line_tally_board board = new();

  source_line_classifier_top #(
    .COUNT_WIDTH(COUNT_W)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_char_byte     (in_char_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_line_done    (out_line_done),
    .out_line_class   (out_line_class),
    .out_blank_count  (out_blank_count),
    .out_comment_count(out_comment_count),
    .out_code_count   (out_code_count),
    .out_file_count   (out_file_count)
  );

  always #2 clk = ~clk;

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !calm_phase && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // check every accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_line_done, out_line_class, out_blank_count,
                         out_comment_count, out_code_count, out_file_count);
  end

  // one input beat; payload holds until accepted
  task automatic send_beat(input slc_pkg::cmd_t cmd, input logic [7:0] value);
    while (!calm_phase && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_char_byte <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(cmd, value);
    beats++;
  endtask

  task automatic send_char(input logic [7:0] c);
    send_beat(slc_pkg::CMD_CHAR, c);
  endtask

  // the byte travels along but must be ignored
  task automatic send_eof();
    send_beat(slc_pkg::CMD_EOF, 8'($urandom));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_ws();
    return $urandom_range(0, 1) ? slc_pkg::CH_SPACE : slc_pkg::CH_TAB;
  endfunction

  // bytes weighted toward the ones the flag rules care about
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 7))
      0:       return slc_pkg::CH_SPACE;
      1:       return slc_pkg::CH_TAB;
      2, 3:    return slc_pkg::CH_SLASH;
      4:       return slc_pkg::CH_STAR;
      5:       return CH_LETTER;
      6:       return CH_CR;
      default: return 8'($urandom_range(33, 126));
    endcase
  endfunction

  // one line: optional indent, an optional lead-in, short text, then newline or end of file
  task automatic send_line();
    int  kind;
    bit  pure_blank;
    kind       = $urandom_range(0, 5);
    pure_blank = (kind == 0);
    repeat ($urandom_range(0, 1)) send_char(pick_ws());
    case (kind)
      1: begin send_char(slc_pkg::CH_SLASH); send_char(slc_pkg::CH_SLASH); end
      2: begin send_char(slc_pkg::CH_SLASH); send_char(slc_pkg::CH_STAR); end
      3: begin send_char(slc_pkg::CH_STAR); send_char(slc_pkg::CH_SLASH); end
      4: send_char(CH_LETTER);
      default: ;
    endcase
    if (!pure_blank) repeat ($urandom_range(0, 3)) send_char(pick_char());
    if ($urandom_range(0, 99) < 20) send_eof();
    else send_char(slc_pkg::CH_NL);
  endtask

  initial begin
    bit held;
    bit paused;
    held   = 1'b0;
    paused = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: end of file with no open line, blank, comment, block comment
    // across lines with trailing code, file ending in newline, extreme and CR
    // bytes, unterminated block comment closed by end of file
    send_eof();
    send_text("\n");
    send_text(" \t\n");
    send_text("//\n");
    send_text("/*a\n");
    send_text("*/b\n");
    send_eof();
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_CR);
    send_char(slc_pkg::CH_NL);
    send_text("/*");
    send_eof();
    send_text("x\n");

    // random traffic until the item budget is spent
    while (beats < RANDOM_BEATS) begin
      calm_phase = (beats >= 900 && beats < 1200);
      if (!held && beats >= 400) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && beats >= 1400) begin
        paused = 1'b1;
        drain();
      end
      case ($urandom_range(0, 19))
        0, 1:    repeat ($urandom_range(1, 4)) send_char(8'($urandom));
        2:       send_eof();
        default: send_line();
      endcase
    end
    calm_phase = 1'b0;

    drain();
    repeat (SETTLE) @(posedge clk);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #1000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
